// File: sv/gtcr_pkg.sv
package gtcr_pkg;

    localparam int COLUMNS_DEFAULT = 128;
    localparam int PAGES_DEFAULT   = 8;
    localparam int GLYPH_WIDTH     = 5;
    localparam int PAGE_W          = 3;
    localparam int GLYPH_BITS      = GLYPH_WIDTH * 8;

    localparam logic       OP_PRINT      = 1'b0;
    localparam logic       OP_SET_CURSOR = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_FIRST     = 8'h20;
    localparam logic [7:0] CHAR_LAST      = 8'h7E;
    localparam logic [7:0] CMD_COL_ADDR   = 8'h21;
    localparam logic [7:0] CMD_PAGE_ADDR  = 8'h22;
    localparam logic [7:0] BLANK_COLUMN   = 8'h00;

    typedef struct packed {
        logic                  has_addr;
        logic                  has_glyph;
        logic [7:0]            addr_col;
        logic [PAGE_W-1:0]     addr_page;
        logic [GLYPH_BITS-1:0] glyph;
    } job_t;

    // Five columns per character, first column in the top byte.
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [6:0] idx);
        logic [GLYPH_BITS-1:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00002f0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147f147f14;
            7'd4:  g = 40'h242a7f2a12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001c224100;
            7'd9:  g = 40'h0041221c00;
            7'd10: g = 40'h14083e0814;
            7'd11: g = 40'h08083e0808;
            7'd12: g = 40'h0000a06000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3e5149453e;
            7'd17: g = 40'h00427f4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454b31;
            7'd20: g = 40'h1814127f10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3c4a494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291e;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324959513e;
            7'd33: g = 40'h7c1211127c;
            7'd34: g = 40'h7f49494936;
            7'd35: g = 40'h3e41414122;
            7'd36: g = 40'h7f4141221c;
            7'd37: g = 40'h7f49494941;
            7'd38: g = 40'h7f09090901;
            7'd39: g = 40'h3e4149497a;
            7'd40: g = 40'h7f0808087f;
            7'd41: g = 40'h00417f4100;
            7'd42: g = 40'h2040413f01;
            7'd43: g = 40'h7f08142241;
            7'd44: g = 40'h7f40404040;
            7'd45: g = 40'h7f020c027f;
            7'd46: g = 40'h7f0408107f;
            7'd47: g = 40'h3e4141413e;
            7'd48: g = 40'h7f09090906;
            7'd49: g = 40'h3e4151215e;
            7'd50: g = 40'h7f09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017f0101;
            7'd53: g = 40'h3f4040403f;
            7'd54: g = 40'h1f2040201f;
            7'd55: g = 40'h3f4038403f;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007f414100;
            7'd60: g = 40'h55aa55aa55;
            7'd61: g = 40'h0041417f00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0003050000;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7f48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487f;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087e090102;
            7'd71: g = 40'h18a4a4a47c;
            7'd72: g = 40'h7f08040478;
            7'd73: g = 40'h00447d4000;
            7'd74: g = 40'h4080847d00;
            7'd75: g = 40'h7f10284400;
            7'd76: g = 40'h00417f4000;
            7'd77: g = 40'h7c04180478;
            7'd78: g = 40'h7c08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'hfc24242418;
            7'd81: g = 40'h18242418fc;
            7'd82: g = 40'h7c08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043f444020;
            7'd85: g = 40'h3c4040207c;
            7'd86: g = 40'h1c2040201c;
            7'd87: g = 40'h3c4030403c;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h1ca0a0a07c;
            7'd90: g = 40'h4464544c44;
            7'd91: g = 40'h00107c8200;
            7'd92: g = 40'h0000ff0000;
            7'd93: g = 40'h00827c1000;
            7'd94: g = 40'h0006090906;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// File: sv/gtcr_cursor.sv
module gtcr_cursor #(
    parameter int COLUMNS = gtcr_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = gtcr_pkg::PAGES_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic          op,
    input  logic [7:0]    char_code,
    input  logic [7:0]    target_page,
    input  logic [7:0]    target_column,
    output gtcr_pkg::job_t job,
    output logic          job_live
);
    import gtcr_pkg::*;

    logic [PAGE_W-1:0] page_reg, page_next;
    logic [7:0]        col_reg, col_next;

    logic              newline, printable, wrap, set_ok;
    logic [PAGE_W-1:0] wrap_page;
    logic [7:0]        base_col;
    logic [8:0]        fit_sum;

    always_comb begin
        fit_sum   = {1'b0, col_reg} + 9'(GLYPH_WIDTH);
        newline   = (char_code == CHAR_NEWLINE);
        printable = (char_code >= CHAR_FIRST) && (char_code <= CHAR_LAST);
        wrap      = (fit_sum >= 9'(COLUMNS)) || newline;
        wrap_page = (page_reg == PAGE_W'(PAGES - 1)) ? '0 : page_reg + PAGE_W'(1);
        base_col  = wrap ? 8'd0 : col_reg;
        set_ok    = (target_page < 8'(PAGES)) && (target_column < 8'(COLUMNS));

        job       = '0;
        job_live  = 1'b0;
        page_next = page_reg;
        col_next  = col_reg;
        case (op)
            OP_SET_CURSOR: begin
                job.has_addr  = 1'b1;
                job.addr_col  = target_column;
                job.addr_page = target_page[PAGE_W-1:0];
                job_live      = set_ok;
                if (set_ok) begin
                    page_next = target_page[PAGE_W-1:0];
                    col_next  = target_column;
                end
            end
            OP_PRINT: begin
                job.has_addr  = wrap;
                job.has_glyph = !newline;
                job.addr_col  = base_col;
                job.addr_page = wrap ? wrap_page : page_reg;
                job.glyph     = printable ? glyph_bits(7'(char_code - CHAR_FIRST)) : '0;
                job_live      = 1'b1;
                page_next     = wrap ? wrap_page : page_reg;
                col_next      = newline ? base_col : base_col + 8'(GLYPH_WIDTH + 1);
            end
            default: begin
                job_live = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg <= '0;
            col_reg  <= '0;
        end else if (accept) begin
            page_reg <= page_next;
            col_reg  <= col_next;
        end
    end

endmodule

// File: sv/gtcr_emit.sv
module gtcr_emit #(
    parameter int COLUMNS = gtcr_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = gtcr_pkg::PAGES_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_load,
    input  gtcr_pkg::job_t job,
    output logic           take,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_is_command,
    output logic [7:0]     m_out_byte,
    output logic           m_last
);
    import gtcr_pkg::*;

    typedef enum logic [3:0] {
        STEP_COL_CMD   = 4'd0,
        STEP_COL_START = 4'd1,
        STEP_COL_END   = 4'd2,
        STEP_PAGE_CMD  = 4'd3,
        STEP_PAGE_LOW  = 4'd4,
        STEP_PAGE_HIGH = 4'd5,
        STEP_GLYPH0    = 4'd6,
        STEP_GLYPH1    = 4'd7,
        STEP_GLYPH2    = 4'd8,
        STEP_GLYPH3    = 4'd9,
        STEP_GLYPH4    = 4'd10,
        STEP_SPACER    = 4'd11
    } step_t;

    job_t       job_reg;
    logic       busy_reg;
    step_t      step_reg;
    logic       m_valid_reg, m_is_command_reg, m_last_reg;
    logic [7:0] m_out_byte_reg;

    logic       out_load, at_last;
    logic [7:0] byte_next;

    always_comb begin
        out_load = busy_reg && (!m_valid_reg || m_ready);
        at_last  = (step_reg == STEP_SPACER) ||
                   ((step_reg == STEP_PAGE_HIGH) && !job_reg.has_glyph);
        take     = !busy_reg || (out_load && at_last);
        case (step_reg)
            STEP_COL_CMD:   byte_next = CMD_COL_ADDR;
            STEP_COL_START: byte_next = job_reg.addr_col;
            STEP_COL_END:   byte_next = 8'(COLUMNS - 1);
            STEP_PAGE_CMD:  byte_next = CMD_PAGE_ADDR;
            STEP_PAGE_LOW:  byte_next = 8'(job_reg.addr_page);
            STEP_PAGE_HIGH: byte_next = 8'(PAGES - 1);
            STEP_GLYPH0:    byte_next = job_reg.glyph[39:32];
            STEP_GLYPH1:    byte_next = job_reg.glyph[31:24];
            STEP_GLYPH2:    byte_next = job_reg.glyph[23:16];
            STEP_GLYPH3:    byte_next = job_reg.glyph[15:8];
            STEP_GLYPH4:    byte_next = job_reg.glyph[7:0];
            default:        byte_next = BLANK_COLUMN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            step_reg         <= STEP_COL_CMD;
            m_valid_reg      <= 1'b0;
            job_reg          <= '0;
            m_is_command_reg <= 1'b0;
            m_out_byte_reg   <= '0;
            m_last_reg       <= 1'b0;
        end else begin
            if (job_load) begin
                busy_reg <= 1'b1;
                step_reg <= job.has_addr ? STEP_COL_CMD : STEP_GLYPH0;
                job_reg  <= job;
            end else if (out_load) begin
                busy_reg <= !at_last;
                step_reg <= step_t'(step_reg + 4'd1);
            end
            if (out_load) begin
                m_valid_reg      <= 1'b1;
                m_is_command_reg <= (step_reg < STEP_GLYPH0);
                m_out_byte_reg   <= byte_next;
                m_last_reg       <= at_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_command = m_is_command_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_last       = m_last_reg;

    // A new job may only arrive once the previous one has handed over its final beat.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load |-> (!busy_reg || (out_load && at_last)))
        else $error("job loaded over a job still in progress");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= STEP_SPACER))
        else $error("sequencer step beyond the spacer column");

    a_cmd_only_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !job_reg.has_glyph) |-> (step_reg < STEP_GLYPH0))
        else $error("address-only job reached the glyph steps");

    a_job_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (job_reg.has_addr || job_reg.has_glyph))
        else $error("busy with a job that produces no beats");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && at_last && !job_load) |=> !busy_reg)
        else $error("sequencer stayed busy after its last beat");

endmodule

// File: sv/glyph_text_column_renderer.sv
// An accepted item is registered into the output sequencer, which then registers each of its beats.
// Throughput: one beat per cycle while m_ready allows; a print emits six or twelve beats, an address
// update six, and an out-of-range cursor update none. The output sequencer sets this rate.
// The next item is accepted on the edge that loads the final beat of the current one.
// Reset (aresetn, synchronous, active low) clears page, column and the sequencer.
module glyph_text_column_renderer #(
    parameter int COLUMNS = gtcr_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = gtcr_pkg::PAGES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_target_page,
    input  logic [7:0] s_target_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_command,
    output logic [7:0] m_out_byte,
    output logic       m_last
);
    import gtcr_pkg::*;

    job_t job;
    logic job_live, accept, take;

    assign s_ready = take;
    assign accept  = s_valid && take;

    gtcr_cursor #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_cursor (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (s_op),
        .char_code    (s_char_code),
        .target_page  (s_target_page),
        .target_column(s_target_column),
        .job          (job),
        .job_live     (job_live)
    );

    gtcr_emit #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_load    (accept && job_live),
        .job         (job),
        .take        (take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_command(m_is_command),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtcr_pkg::*;

    localparam int COLS        = COLUMNS_DEFAULT;
    localparam int PAGE_COUNT  = PAGES_DEFAULT;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [7:0] page;
        logic [7:0] col;
    } text_item_t;

    typedef struct {
        text_item_t  item;
        int unsigned gap;
        bit          drain;
    } queued_item_t;

    typedef struct packed {
        logic       is_cmd;
        logic [7:0] data;
        logic       last;
    } panel_beat_t;

    logic       aclk;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic       s_op            = OP_PRINT;
    logic [7:0] s_char_code     = 8'h00;
    logic [7:0] s_target_page   = 8'h00;
    logic [7:0] s_target_column = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_is_command;
    logic [7:0] m_out_byte;
    logic       m_last;

    queued_item_t pending_items[$];
    panel_beat_t  due_bytes[$];
    queued_item_t next_item;
    panel_beat_t  wanted;

    logic [PAGE_W-1:0] text_page = '0;
    logic [7:0]        text_col  = '0;

    logic        s_took     = 1'b0;
    logic        m_took     = 1'b0;
    int unsigned gap_done   = 0;
    int          sink_wait  = 0;
    int unsigned cycle_count = 0;
    int unsigned errors      = 0;
    int unsigned beats_checked = 0;
    int unsigned n_glyphs = 0, n_newlines = 0, n_wraps = 0, n_moves = 0, n_ignored = 0;

    bit [39:0] font_cols [0:94] = '{
        40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
        40'h14083e0814, 40'h08083e0808, 40'h0000a06000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
        40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7c1211127c, 40'h7f49494936,
        40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
        40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
        40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h55aa55aa55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
        40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
        40'h087e090102, 40'h18a4a4a47c, 40'h7f08040478, 40'h00447d4000, 40'h4080847d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'hfc24242418, 40'h18242418fc, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
        40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h1ca0a0a07c,
        40'h4464544c44, 40'h00107c8200, 40'h0000ff0000, 40'h00827c1000, 40'h0006090906
    };

    glyph_text_column_renderer #(
        .COLUMNS(COLS),
        .PAGES  (PAGE_COUNT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_char_code    (s_char_code),
        .s_target_page  (s_target_page),
        .s_target_column(s_target_column),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_command   (m_is_command),
        .m_out_byte     (m_out_byte),
        .m_last         (m_last)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    task automatic flag(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic queue_item(input logic op, input logic [7:0] ch, input logic [7:0] page,
                              input logic [7:0] col, input int unsigned gap, input bit drain);
        queued_item_t q;
        q.item  = {op, ch, page, col};
        q.gap   = gap;
        q.drain = drain;
        pending_items.push_back(q);
    endtask

    // Works out the panel bytes that one accepted item causes and updates the cursor.
    function automatic void render_item(input text_item_t it);
        logic        addr;
        logic        glyph_on;
        logic        newline;
        logic [39:0] g;
        logic [47:0] addr_bytes;
        logic [47:0] glyph_bytes;
        logic [47:0] word;
        panel_beat_t beat;
        int          total;
        int          j;
        addr     = 1'b0;
        glyph_on = 1'b0;
        if (it.op == OP_SET_CURSOR) begin
            if (int'(it.page) < PAGE_COUNT && int'(it.col) < COLS) begin
                text_page = it.page[PAGE_W-1:0];
                text_col  = it.col;
                addr      = 1'b1;
                n_moves++;
            end else begin
                n_ignored++;
            end
        end else begin
            newline = (it.ch == CHAR_NEWLINE);
            if (newline || int'(text_col) + GLYPH_WIDTH >= COLS) begin
                text_page = (int'(text_page) + 1 >= PAGE_COUNT) ? '0 : text_page + 1'b1;
                text_col  = '0;
                addr      = 1'b1;
                if (!newline) begin
                    n_wraps++;
                end
            end
            if (newline) begin
                n_newlines++;
            end else begin
                glyph_on = 1'b1;
                n_glyphs++;
            end
        end
        addr_bytes = {CMD_COL_ADDR, text_col, 8'(COLS - 1),
                      CMD_PAGE_ADDR, 8'(text_page), 8'(PAGE_COUNT - 1)};
        g = (it.ch >= CHAR_FIRST && it.ch <= CHAR_LAST) ?
            font_cols[7'(it.ch - CHAR_FIRST)] : '0;
        glyph_bytes = {g, BLANK_COLUMN};
        if (glyph_on) begin
            text_col = text_col + 8'(GLYPH_WIDTH + 1);
        end
        total = (addr ? 6 : 0) + (glyph_on ? 6 : 0);
        for (int k = 0; k < total; k++) begin
            beat.is_cmd = addr && k < 6;
            word        = beat.is_cmd ? addr_bytes : glyph_bytes;
            j           = k % 6;
            beat.data   = word[47 - 8 * j -: 8];
            beat.last   = (k == total - 1);
            due_bytes.push_back(beat);
        end
    endfunction

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_took)) begin
            if (pending_items.size() != 0 && gap_done >= pending_items[0].gap
                    && !(pending_items[0].drain && due_bytes.size() != 0)) begin
                next_item       = pending_items.pop_front();
                s_op            <= next_item.item.op;
                s_char_code     <= next_item.item.ch;
                s_target_page   <= next_item.item.page;
                s_target_column <= next_item.item.col;
                s_valid         <= 1'b1;
                gap_done        <= 0;
            end else begin
                s_valid <= 1'b0;
                if (pending_items.size() != 0 && gap_done < pending_items[0].gap) begin
                    gap_done <= gap_done + 1;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took) begin
                sink_wait = ((beats_checked / 60) % 4 == 3) ? 0 : $urandom_range(0, 6);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            m_took <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                beats_checked++;
                if (due_bytes.size() == 0) begin
                    flag($sformatf("beat with nothing expected: cmd=%0b byte=%02h last=%0b",
                                   m_is_command, m_out_byte, m_last));
                end else begin
                    wanted = due_bytes.pop_front();
                    if (m_is_command !== wanted.is_cmd) begin
                        flag($sformatf("is_command %0b, expected %0b",
                                       m_is_command, wanted.is_cmd));
                    end
                    if (m_out_byte !== wanted.data) begin
                        flag($sformatf("out_byte %02h, expected %02h", m_out_byte, wanted.data));
                    end
                    if (m_last !== wanted.last) begin
                        flag($sformatf("last %0b, expected %0b", m_last, wanted.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                render_item({s_op, s_char_code, s_target_page, s_target_column});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned gap;
        logic [7:0]  ch;

        // Directed: field extremes, blanks for unprintable codes, newlines, the fit
        // test either side of the right edge, the page wrap and rejected cursor moves.
        queue_item(OP_PRINT, 8'h41, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_PRINT, CHAR_FIRST, 8'h00, 8'h00, $urandom_range(0, 6), 1'b0);
        queue_item(OP_PRINT, CHAR_LAST, 8'h00, 8'h00, $urandom_range(0, 6), 1'b0);
        queue_item(OP_PRINT, 8'h1F, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_PRINT, 8'h7F, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_PRINT, 8'hFF, 8'hFF, 8'hFF, $urandom_range(0, 6), 1'b0);
        queue_item(OP_PRINT, 8'h00, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_PRINT, CHAR_NEWLINE, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_SET_CURSOR, 8'hFF, 8'd7, 8'd127, $urandom_range(0, 6), 1'b0);
        queue_item(OP_PRINT, 8'h5A, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'd8, 8'd0, 0, 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'd0, 8'd128, $urandom_range(0, 6), 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'hFF, 8'hFF, 0, 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'd3, 8'd122, 0, 1'b0);
        queue_item(OP_PRINT, 8'h67, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_PRINT, 8'h71, 8'h00, 8'h00, $urandom_range(0, 6), 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'd5, 8'd123, 0, 1'b0);
        queue_item(OP_PRINT, 8'h23, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'd7, 8'd0, 0, 1'b0);
        queue_item(OP_PRINT, CHAR_NEWLINE, 8'h00, 8'h00, 0, 1'b0);
        queue_item(OP_PRINT, CHAR_NEWLINE, 8'hFF, 8'hFF, $urandom_range(0, 6), 1'b0);
        queue_item(OP_SET_CURSOR, 8'h00, 8'd0, 8'd0, 0, 1'b1);

        for (int i = 0; i < 350; i++) begin
            gap = ((i / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
            r   = $urandom_range(0, 99);
            if (r < 62) begin
                queue_item(OP_PRINT, 8'($urandom_range(CHAR_FIRST, CHAR_LAST)),
                           8'($urandom), 8'($urandom), gap, i % 100 == 99);
            end else if (r < 70) begin
                queue_item(OP_PRINT, CHAR_NEWLINE, 8'($urandom), 8'($urandom),
                           gap, i % 100 == 99);
            end else if (r < 76) begin
                ch = 8'($urandom);
                if (ch >= CHAR_FIRST && ch <= CHAR_LAST) begin
                    ch = ch ^ 8'h80;
                end
                queue_item(OP_PRINT, ch, 8'($urandom), 8'($urandom), gap, i % 100 == 99);
            end else if (r < 92) begin
                queue_item(OP_SET_CURSOR, 8'($urandom), 8'($urandom_range(0, PAGE_COUNT - 1)),
                           8'($urandom_range(0, 1) ? $urandom_range(COLS - 18, COLS - 1)
                                                    : $urandom_range(0, COLS - 1)),
                           gap, i % 100 == 99);
            end else begin
                queue_item(OP_SET_CURSOR, 8'($urandom), 8'($urandom), 8'($urandom),
                           gap, i % 100 == 99);
            end
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("summary: %0d glyphs (%0d after a right-edge wrap), %0d newlines,",
                 n_glyphs, n_wraps, n_newlines);
        $display("summary: %0d cursor moves, %0d rejected moves, %0d panel beats checked",
                 n_moves, n_ignored, beats_checked);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
